/* hw/rtl/fplrq_pkg.sv */
`default_nettype none

package fplrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int NUM_CLASSES = 4;

  localparam int CLS_W   = 2;
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int TOTAL_W = CNT_W + CLS_W;
  localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(MEM_DEPTH);

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef logic [CLS_W-1:0]   cls_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ID_BITS-1:0] id_t;

endpackage

`default_nettype wire

/* hw/rtl/four_level_priority_ready_queue.sv */
`default_nettype none

// Four-class strict-priority ready queue. Class 0 (system) is served first, class 3 (batch)
// last, first in first out within a class. The block takes one word per clock: busy is
// never raised, so start may be held high every cycle. Each accepted word gives one result
// word in the following cycle, shown for one cycle with out_valid; the receiver cannot
// stall it, so it must take every result as it comes. The thread id comes from the
// registered read port of the 64-entry thread id store; queue pointers and counts are
// updated at the accepting edge, so a dequeue may directly follow an enqueue. An enqueue
// to a full class is dropped with out_accepted low; a dequeue with every class empty gives
// out_found low and id 0. The counts are those after the word has taken effect.
module four_level_priority_ready_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_thread_id,
  input  wire logic [1:0] in_prio_class,
  output logic            out_valid,
  output logic            out_found,
  output logic [7:0]      out_thread_id,
  output logic [1:0]      out_class,
  output logic            out_accepted,
  output logic [4:0]      out_system_count,
  output logic [4:0]      out_interactive_count,
  output logic [4:0]      out_normal_count,
  output logic [4:0]      out_batch_count,
  output logic [6:0]      out_total_count
);

  fplrq_pkg::ptr_t   head_r  [fplrq_pkg::NUM_CLASSES];
  fplrq_pkg::ptr_t   head_nxt[fplrq_pkg::NUM_CLASSES];
  fplrq_pkg::ptr_t   tail_r  [fplrq_pkg::NUM_CLASSES];
  fplrq_pkg::ptr_t   tail_nxt[fplrq_pkg::NUM_CLASSES];
  fplrq_pkg::cnt_t   occ_r   [fplrq_pkg::NUM_CLASSES];
  fplrq_pkg::cnt_t   occ_nxt [fplrq_pkg::NUM_CLASSES];
  fplrq_pkg::total_t total_r;
  fplrq_pkg::total_t total_nxt;

  fplrq_pkg::id_t    mem [fplrq_pkg::MEM_DEPTH];
  fplrq_pkg::id_t    rd_data_r;

  logic              out_valid_r;
  logic              found_r;
  fplrq_pkg::cls_t   class_r;
  logic              accepted_r;

  logic              accept;
  logic              sel_found;
  fplrq_pkg::cls_t   sel_cls;
  fplrq_pkg::ptr_t   head_sel;
  fplrq_pkg::ptr_t   tail_cls;
  fplrq_pkg::cnt_t   occ_cls;
  logic              enq_ok;
  logic              deq_ok;
  fplrq_pkg::addr_t  wr_addr;
  fplrq_pkg::addr_t  rd_addr;

  function automatic fplrq_pkg::ptr_t ptr_inc(input fplrq_pkg::ptr_t p);
    return (p == fplrq_pkg::ptr_t'(fplrq_pkg::QUEUE_DEPTH - 1)) ? '0 :
           p + fplrq_pkg::ptr_t'(1);
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // priority select and per-class lookups
  always_comb begin
    sel_found = 1'b0;
    sel_cls   = '0;
    for (int c = fplrq_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
      if (occ_r[c] != '0) begin
        sel_found = 1'b1;
        sel_cls   = fplrq_pkg::cls_t'(c);
      end
    end
    head_sel = '0;
    tail_cls = '0;
    occ_cls  = '0;
    for (int c = 0; c < fplrq_pkg::NUM_CLASSES; c++) begin
      if (fplrq_pkg::cls_t'(c) == sel_cls) begin
        head_sel = head_r[c];
      end
      if (fplrq_pkg::cls_t'(c) == in_prio_class) begin
        tail_cls = tail_r[c];
        occ_cls  = occ_r[c];
      end
    end
  end

  assign enq_ok = accept && (in_kind == fplrq_pkg::KIND_ENQ) &&
                  (occ_cls != fplrq_pkg::cnt_t'(fplrq_pkg::QUEUE_DEPTH));
  assign deq_ok = accept && (in_kind == fplrq_pkg::KIND_DEQ) && sel_found;

  assign wr_addr = fplrq_pkg::addr_t'(in_prio_class) *
                   fplrq_pkg::addr_t'(fplrq_pkg::QUEUE_DEPTH) + fplrq_pkg::addr_t'(tail_cls);
  assign rd_addr = fplrq_pkg::addr_t'(sel_cls) *
                   fplrq_pkg::addr_t'(fplrq_pkg::QUEUE_DEPTH) + fplrq_pkg::addr_t'(head_sel);

  always_comb begin
    total_nxt = '0;
    for (int c = 0; c < fplrq_pkg::NUM_CLASSES; c++) begin
      head_nxt[c] = head_r[c];
      tail_nxt[c] = tail_r[c];
      occ_nxt[c]  = occ_r[c];
      if (enq_ok && (fplrq_pkg::cls_t'(c) == in_prio_class)) begin
        tail_nxt[c] = ptr_inc(tail_r[c]);
        occ_nxt[c]  = occ_r[c] + fplrq_pkg::cnt_t'(1);
      end
      if (deq_ok && (fplrq_pkg::cls_t'(c) == sel_cls)) begin
        head_nxt[c] = ptr_inc(head_r[c]);
        occ_nxt[c]  = occ_r[c] - fplrq_pkg::cnt_t'(1);
      end
      total_nxt = total_nxt + fplrq_pkg::total_t'(occ_nxt[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < fplrq_pkg::NUM_CLASSES; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
        occ_r[c]  <= '0;
      end
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int c = 0; c < fplrq_pkg::NUM_CLASSES; c++) begin
        head_r[c] <= head_nxt[c];
        tail_r[c] <= tail_nxt[c];
        occ_r[c]  <= occ_nxt[c];
      end
      total_r     <= total_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found_r    <= deq_ok;
      class_r    <= deq_ok ? sel_cls : '0;
      accepted_r <= enq_ok;
    end
  end

  // thread id store
  always_ff @(posedge clk) begin
    if (enq_ok) begin
      mem[wr_addr] <= fplrq_pkg::id_t'(in_thread_id);
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid             = out_valid_r;
  assign out_found             = found_r;
  assign out_thread_id         = found_r ? 8'(rd_data_r) : 8'd0;
  assign out_class             = class_r;
  assign out_accepted          = accepted_r;
  assign out_system_count      = 5'(occ_r[0]);
  assign out_interactive_count = 5'(occ_r[1]);
  assign out_normal_count      = 5'(occ_r[2]);
  assign out_batch_count       = 5'(occ_r[3]);
  assign out_total_count       = 7'(total_r);

  a_one_result_per_word: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted word gave no result");

  a_found_excludes_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_accepted))
    else $error("result both dequeued and enqueued");

  a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (total_r == fplrq_pkg::total_t'(occ_r[0]) + fplrq_pkg::total_t'(occ_r[1]) +
                   fplrq_pkg::total_t'(occ_r[2]) + fplrq_pkg::total_t'(occ_r[3])))
    else $error("total count out of step with class counts");

  a_dequeue_empty_keeps_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == fplrq_pkg::KIND_DEQ && occ_r[0] == '0 && occ_r[1] == '0 &&
     occ_r[2] == '0 && occ_r[3] == '0) |=> (total_r == '0 && !out_found))
    else $error("dequeue from empty queue changed state");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  typedef enum logic [1:0] {
    CLS_SYSTEM      = 2'd0,
    CLS_INTERACTIVE = 2'd1,
    CLS_NORMAL      = 2'd2,
    CLS_BATCH       = 2'd3
  } prio_t;

  typedef struct packed {
    logic              found;
    fplrq_pkg::id_t    tid;
    fplrq_pkg::cls_t   cls;
    logic              accepted;
    fplrq_pkg::cnt_t   sys_cnt;
    fplrq_pkg::cnt_t   inter_cnt;
    fplrq_pkg::cnt_t   norm_cnt;
    fplrq_pkg::cnt_t   batch_cnt;
    fplrq_pkg::total_t total;
  } qres_t;

  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_kind;
  logic [7:0] in_thread_id;
  logic [1:0] in_prio_class;
  logic       out_valid;
  logic       out_found;
  logic [7:0] out_thread_id;
  logic [1:0] out_class;
  logic       out_accepted;
  logic [4:0] out_system_count;
  logic [4:0] out_interactive_count;
  logic [4:0] out_normal_count;
  logic [4:0] out_batch_count;
  logic [6:0] out_total_count;

  // ready queue mirror
  fplrq_pkg::id_t ready_slots [fplrq_pkg::NUM_CLASSES][fplrq_pkg::QUEUE_DEPTH];
  int    rd_ptr [fplrq_pkg::NUM_CLASSES];
  int    wr_ptr [fplrq_pkg::NUM_CLASSES];
  int    fill   [fplrq_pkg::NUM_CLASSES];

  qres_t due_results [$];
  qres_t due_word;
  int    mismatches = 0;
  int    cycles = 0;
  int    n_stored = 0;
  int    n_dropped = 0;
  int    n_popped = 0;
  int    n_empty_pops = 0;
  bit    idle_on = 1'b1;

  four_level_priority_ready_queue dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_kind               (in_kind),
    .in_thread_id          (in_thread_id),
    .in_prio_class         (in_prio_class),
    .out_valid             (out_valid),
    .out_found             (out_found),
    .out_thread_id         (out_thread_id),
    .out_class             (out_class),
    .out_accepted          (out_accepted),
    .out_system_count      (out_system_count),
    .out_interactive_count (out_interactive_count),
    .out_normal_count      (out_normal_count),
    .out_batch_count       (out_batch_count),
    .out_total_count       (out_total_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("four_level_priority_ready_queue: mismatch");
      $finish;
    end
  end

  function automatic qres_t apply_word(logic kind, fplrq_pkg::id_t tid, prio_t cls);
    qres_t r;
    int    c;
    int    sum;
    r = '0;
    c = int'(cls);
    if (kind == fplrq_pkg::KIND_ENQ) begin
      if (fill[c] < fplrq_pkg::QUEUE_DEPTH) begin
        ready_slots[c][wr_ptr[c]] = tid;
        wr_ptr[c] = (wr_ptr[c] + 1) % fplrq_pkg::QUEUE_DEPTH;
        fill[c]++;
        r.accepted = 1'b1;
        n_stored++;
      end else begin
        n_dropped++;
      end
    end else begin
      for (c = 0; c < fplrq_pkg::NUM_CLASSES; c++) begin
        if (!r.found && fill[c] != 0) begin
          r.found = 1'b1;
          r.tid   = ready_slots[c][rd_ptr[c]];
          r.cls   = fplrq_pkg::cls_t'(c);
          rd_ptr[c] = (rd_ptr[c] + 1) % fplrq_pkg::QUEUE_DEPTH;
          fill[c]--;
        end
      end
      if (r.found) n_popped++;
      else n_empty_pops++;
    end
    sum = 0;
    for (c = 0; c < fplrq_pkg::NUM_CLASSES; c++) sum += fill[c];
    r.sys_cnt   = fplrq_pkg::cnt_t'(fill[0]);
    r.inter_cnt = fplrq_pkg::cnt_t'(fill[1]);
    r.norm_cnt  = fplrq_pkg::cnt_t'(fill[2]);
    r.batch_cnt = fplrq_pkg::cnt_t'(fill[3]);
    r.total     = fplrq_pkg::total_t'(sum);
    return r;
  endfunction

  task automatic check_field(string name, int expv, int actv);
    if (expv != actv) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, expv, actv);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        $display("%0t: result word with nothing pending, id %0d", $time, out_thread_id);
        mismatches++;
      end else begin
        due_word = due_results.pop_front();
        check_field("found", due_word.found, out_found);
        check_field("thread_id", due_word.tid, out_thread_id);
        check_field("class", due_word.cls, out_class);
        check_field("accepted", due_word.accepted, out_accepted);
        check_field("system_count", due_word.sys_cnt, out_system_count);
        check_field("interactive_count", due_word.inter_cnt, out_interactive_count);
        check_field("normal_count", due_word.norm_cnt, out_normal_count);
        check_field("batch_count", due_word.batch_cnt, out_batch_count);
        check_field("total_count", due_word.total, out_total_count);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_word(logic kind, fplrq_pkg::id_t tid, prio_t cls);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_kind       <= kind;
    in_thread_id  <= tid;
    in_prio_class <= cls;
    @(posedge clk);
    while (busy) @(posedge clk);
    due_results.push_back(apply_word(kind, tid, cls));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_empty_dequeue();
    send_word(fplrq_pkg::KIND_DEQ, 8'hFF, CLS_BATCH);
    send_word(fplrq_pkg::KIND_DEQ, 8'h00, CLS_SYSTEM);
  endtask

  task automatic test_priority_order();
    send_word(fplrq_pkg::KIND_ENQ, 8'hFF, CLS_BATCH);
    send_word(fplrq_pkg::KIND_ENQ, 8'h00, CLS_NORMAL);
    send_word(fplrq_pkg::KIND_ENQ, 8'hA5, CLS_INTERACTIVE);
    send_word(fplrq_pkg::KIND_ENQ, 8'h5A, CLS_SYSTEM);
    repeat (5) send_word(fplrq_pkg::KIND_DEQ, fplrq_pkg::id_t'($urandom),
                         prio_t'($urandom_range(0, 3)));
  endtask

  task automatic test_full_class();
    int i;
    for (i = 0; i <= fplrq_pkg::QUEUE_DEPTH; i++)
      send_word(fplrq_pkg::KIND_ENQ, fplrq_pkg::id_t'(i * 15), CLS_BATCH);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int    r;
    int    i;
    int    enq_pct;
    prio_t favored;
    prio_t cls;
    for (r = 0; r < 25; r++) begin
      case (r % 4)
        0: enq_pct = 90;
        1: enq_pct = 40;
        2: enq_pct = 60;
        default: enq_pct = 10;
      endcase
      favored = prio_t'($urandom_range(0, 3));
      idle_on = ($urandom_range(0, 3) != 0);
      for (i = 0; i < 50; i++) begin
        cls = ($urandom_range(0, 1) != 0) ? favored : prio_t'($urandom_range(0, 3));
        if ($urandom_range(1, 100) <= enq_pct)
          send_word(fplrq_pkg::KIND_ENQ, fplrq_pkg::id_t'($urandom), cls);
        else
          send_word(fplrq_pkg::KIND_DEQ, fplrq_pkg::id_t'($urandom), cls);
      end
      if (r % 6 == 5) wait_drained();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_kind       = fplrq_pkg::KIND_ENQ;
    in_thread_id  = '0;
    in_prio_class = CLS_SYSTEM;
    for (int c = 0; c < fplrq_pkg::NUM_CLASSES; c++) begin
      rd_ptr[c] = 0;
      wr_ptr[c] = 0;
      fill[c]   = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_dequeue();
    test_priority_order();
    test_full_class();
    test_random_traffic();

    wait_drained();
    repeat (4) @(posedge clk);
    $display("covered %0d stored and %0d dropped enqueues, %0d dequeues with a thread",
             n_stored, n_dropped, n_popped);
    $display("and %0d dequeues on an empty queue, with and without sender gaps", n_empty_pops);
    if (mismatches == 0) begin
      $display("four_level_priority_ready_queue: match");
    end else begin
      $display("four_level_priority_ready_queue: mismatch");
    end
    $finish;
  end

endmodule
